@@ design/lpsw_pkg.sv @@
// ----------------------------------------------------------------------------
// lpsw_pkg
// Types, constants and the period curve for the square-wave generator.
// ----------------------------------------------------------------------------
package lpsw_pkg;

  localparam int KNOB_W   = 10;
  localparam int LEVEL_W  = 8;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 7;
  localparam int SUM_W    = KNOB_W + 1;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic [KNOB_W-1:0]   knob_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef enum logic {
    OP_KNOB = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_FREQ_OFFSET      = 2'd0,
    REG_BACKGROUND_LEVEL = 2'd1,
    REG_PEDAL_LEVEL      = 2'd2
  } reg_idx_t;

  localparam knob_t   RST_FREQ_OFFSET      = 10'd132;
  localparam level_t  RST_BACKGROUND_LEVEL = 8'd10;
  localparam level_t  RST_PEDAL_LEVEL      = 8'd90;
  localparam period_t RST_HALF             = 16'h4000;
  localparam period_t RST_COMPARE          = 16'd2560;
  localparam period_t TAIL_PERIOD          = 16'd8;

  localparam int TOGGLE_BIT = 6;

  // piecewise-linear decaying curve, 13 segments of 128 sums each
  function automatic period_t curve_total(input sum_t x);
    logic [16:0] xw;
    logic [16:0] r;
    begin
      xw = {6'd0, x};
      case (x[SUM_W-1:7])
        4'd0:    r = 17'd65535 - (xw << 8);
        4'd1:    r = 17'd49152 - (xw << 7);
        4'd2:    r = 17'd32768 - (xw << 6);
        4'd3:    r = 17'd20480 - (xw << 5);
        4'd4:    r = 17'd12288 - (xw << 4);
        4'd5:    r = 17'd7168  - (xw << 3);
        4'd6:    r = 17'd4096  - (xw << 2);
        4'd7:    r = 17'd2304  - (xw << 1);
        4'd8:    r = 17'd1280  - xw;
        4'd9:    r = 17'd704   - (xw >> 1);
        4'd10:   r = 17'd384   - (xw >> 2);
        4'd11:   r = 17'd208   - (xw >> 3);
        4'd12:   r = 17'd112   - (xw >> 4);
        default: r = {1'b0, TAIL_PERIOD};
      endcase
      return r[PERIOD_W-1:0];
    end
  endfunction

endpackage

@@ design/log_period_square_wave_generator.sv @@
// ----------------------------------------------------------------------------
// log_period_square_wave_generator
// Square wave whose period follows a decaying curve of a frequency knob,
// with the split between half-periods set by a duty knob.
// ----------------------------------------------------------------------------
// An accepted word passes through the input stage and then the result stage to its result word.
// Throughput: one word per cycle unless out_stall holds the result stage; the curve
// lookup sits in the input stage, the 16x10 duty multiply and tick logic in the result stage.
// Reset: synchronous, active low; restores registers, half-periods, counter,
// phase and outputs to their initial values and empties both stages.
// ----------------------------------------------------------------------------
module log_period_square_wave_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  lpsw_pkg::knob_t               in_freq_knob,
  input  lpsw_pkg::knob_t               in_duty_knob,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_pin_high,
  output lpsw_pkg::level_t              out_pwm_level,
  output lpsw_pkg::period_t             out_compare_period,
  output logic                          out_toggled,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lpsw_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [lpsw_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [lpsw_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import lpsw_pkg::*;

  knob_t   freq_offset_r;
  level_t  background_level_r;
  level_t  pedal_level_r;

  logic    s1_valid_r;
  op_t     s1_op_r;
  period_t s1_total_r;
  knob_t   s1_duty_r;

  period_t first_half_r;
  period_t second_half_r;
  count_t  tick_count_r;
  logic    phase_r;
  logic    pin_r;
  level_t  level_r;
  period_t compare_r;

  logic    out_valid_r;
  logic    out_toggled_r;

  logic    adv;
  logic    take;
  logic    cfg_wr;
  reg_idx_t cfg_idx;

  sum_t        knob_sum;
  logic [25:0] duty_prod;
  period_t     p1;
  period_t     first_half_nxt;
  period_t     second_half_nxt;
  count_t      tick_inc;
  count_t      tick_count_nxt;
  logic        toggle;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_FREQ_OFFSET:      cfg_prdata = {{(DATA_W-KNOB_W){1'b0}}, freq_offset_r};
      REG_BACKGROUND_LEVEL: cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, background_level_r};
      REG_PEDAL_LEVEL:      cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, pedal_level_r};
      default:              cfg_prdata = '0;
    endcase
  end

  assign adv      = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign take     = in_valid & ~in_stall;

  assign knob_sum = {1'b0, in_freq_knob} + {1'b0, freq_offset_r};

  assign duty_prod = {10'd0, s1_total_r} * {16'd0, s1_duty_r};
  assign p1        = (duty_prod[25:10] == '0) ? 16'd1 : duty_prod[25:10];

  assign tick_inc = tick_count_r + 7'd1;
  assign toggle   = (s1_op_r == OP_TICK) & tick_inc[TOGGLE_BIT];

  always_comb begin
    first_half_nxt  = first_half_r;
    second_half_nxt = second_half_r;
    tick_count_nxt  = tick_count_r;
    if (s1_op_r == OP_KNOB) begin
      first_half_nxt  = p1;
      second_half_nxt = s1_total_r - p1;
    end else begin
      tick_count_nxt = toggle ? '0 : tick_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_offset_r      <= RST_FREQ_OFFSET;
      background_level_r <= RST_BACKGROUND_LEVEL;
      pedal_level_r      <= RST_PEDAL_LEVEL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FREQ_OFFSET:      freq_offset_r      <= cfg_pwdata[KNOB_W-1:0];
        REG_BACKGROUND_LEVEL: background_level_r <= cfg_pwdata[LEVEL_W-1:0];
        REG_PEDAL_LEVEL:      pedal_level_r      <= cfg_pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op_r    <= op_t'(in_operation);
      s1_total_r <= curve_total(knob_sum);
      s1_duty_r  <= in_duty_knob;
    end
  end

  // result stage and generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      out_toggled_r <= 1'b0;
      first_half_r  <= RST_HALF;
      second_half_r <= RST_HALF;
      tick_count_r  <= '0;
      phase_r       <= 1'b0;
      pin_r         <= 1'b0;
      level_r       <= '0;
      compare_r     <= RST_COMPARE;
    end else begin
      if (adv) begin
        out_valid_r   <= 1'b1;
        out_toggled_r <= toggle;
        first_half_r  <= first_half_nxt;
        second_half_r <= second_half_nxt;
        tick_count_r  <= tick_count_nxt;
        if (toggle) begin
          phase_r <= ~phase_r;
          if (!phase_r) begin
            pin_r     <= 1'b0;
            level_r   <= pedal_level_r;
            compare_r <= first_half_r;
          end else begin
            pin_r     <= 1'b1;
            level_r   <= background_level_r;
            compare_r <= second_half_r;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pin_high       = pin_r;
  assign out_pwm_level      = level_r;
  assign out_compare_period = compare_r;
  assign out_toggled        = out_toggled_r;

endmodule
